// File: rtl/nsp_pkg.sv
// ----------------------------------------------------------------------------
// nsp_pkg
// Types, codes and helpers shared by the NMEA sentence parser files.
// ----------------------------------------------------------------------------
package nsp_pkg;

  localparam int BYTE_W      = 8;
  localparam int FIELD_IDX_W = 5;
  localparam int STATUS_W    = 2;

  // sentence status codes
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADSTART = 2'd3;

  // special characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;

  // hex digit value, or NOT_HEX when the byte is no hex digit
  localparam logic [4:0] NOT_HEX = 5'd16;

  typedef struct packed {
    logic [BYTE_W-1:0]      field_char;
    logic                   char_valid;
    logic [FIELD_IDX_W-1:0] field_index;
    logic                   field_end;
    logic                   sentence_end;
    logic [STATUS_W-1:0]    status;
    logic [BYTE_W-1:0]      computed_sum;
  } result_t;

  function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] b);
    logic [4:0] v;
    v = NOT_HEX;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = 5'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = 5'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = 5'(b - 8'h41 + 8'd10);
    end
    return v;
  endfunction

endpackage

// File: rtl/nsp_byte_if.sv
// ----------------------------------------------------------------------------
// nsp_byte_if
// Byte channel into the parser: one sentence byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface nsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/nsp_result_if.sv
// ----------------------------------------------------------------------------
// nsp_result_if
// Result channel out of the parser: one result item per input byte.
// ----------------------------------------------------------------------------
interface nsp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] field_char;
  logic       char_valid;
  logic [4:0] field_index;
  logic       field_end;
  logic       sentence_end;
  logic [1:0] status;
  logic [7:0] computed_sum;

  modport source(output valid, output field_char, output char_valid,
                 output field_index, output field_end, output sentence_end,
                 output status, output computed_sum, input ready);
  modport sink(input valid, input field_char, input char_valid,
               input field_index, input field_end, input sentence_end,
               input status, input computed_sum, output ready);
endinterface

// File: rtl/nmea_sentence_parser.sv
// An accepted byte passes the input register and then the result register
//   before its result item is valid. Throughput: one byte per cycle unless a
//   low results.ready stalls it; one decode stage sits between the registers.
// Reset (rst, synchronous): empties both registers and returns the parser to
//   waiting for a start byte with checksum, field count and digit flags clear.
// ----------------------------------------------------------------------------
// nmea_sentence_parser
// NMEA 0183 sentence parser: field split and XOR checksum check, one result
// item per input byte.
// ----------------------------------------------------------------------------
module nmea_sentence_parser #(
  parameter int MAX_FIELDS = 32
) (
  input  logic                clk,
  input  logic                rst,
  nsp_byte_if.sink            bytes,
  nsp_result_if.source        results
);
  import nsp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_ready;

  logic       res_valid;
  result_t    res;
  result_t    res_next;
  logic       res_adv;

  assign res_adv     = s1_valid && (!res_valid || results.ready);
  assign s1_ready    = !s1_valid || res_adv;
  assign bytes.ready = s1_ready;

  nsp_core #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (res_adv),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .result    (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && s1_ready) begin
      s1_byte <= bytes.data_byte;
      s1_last <= bytes.last_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_adv) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_adv) begin
      res <= res_next;
    end
  end

  assign results.valid        = res_valid;
  assign results.field_char   = res.field_char;
  assign results.char_valid   = res.char_valid;
  assign results.field_index  = res.field_index;
  assign results.field_end    = res.field_end;
  assign results.sentence_end = res.sentence_end;
  assign results.status       = res.status;
  assign results.computed_sum = res.computed_sum;

`ifndef SYNTHESIS
  a_status_on_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_NONE |-> res.sentence_end)
    else $error("status reported before the sentence end");

  a_char_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.char_valid && res.field_end |-> res.sentence_end)
    else $error("character closes a field on a byte other than the last");

  a_badstart_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_BADSTART |->
      !res.char_valid && !res.field_end && res.computed_sum == 8'h00)
    else $error("bad start sentence produced body output");
`endif

endmodule

// File: rtl/nsp_core.sv
// ----------------------------------------------------------------------------
// nsp_core
// Sentence state and per-byte decode: phase, running checksum, field count
// and digit match flags, plus the result for the presented byte.
// ----------------------------------------------------------------------------
module nsp_core #(
  parameter int MAX_FIELDS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output nsp_pkg::result_t        result
);
  import nsp_pkg::*;

  localparam int FCW = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
  localparam logic [FCW-1:0] FIELD_MAX = FCW'(MAX_FIELDS - 1);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_BODY  = 3'd1;
  localparam logic [2:0] PH_DIG1  = 3'd2;
  localparam logic [2:0] PH_DIG2  = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;
  localparam logic [2:0] PH_BAD   = 3'd5;

  logic [2:0]     phase, phase_next;
  logic [7:0]     running_xor, running_xor_next;
  logic [FCW-1:0] field_count, field_count_next;
  logic [1:0]     digit_ok, digit_ok_next;

  logic [4:0]     hex_v;
  logic [FCW-1:0] fidx;
  logic [1:0]     chk_status;
  logic [1:0]     st;

  assign hex_v      = hex_value(data_byte);
  assign chk_status = (digit_ok == 2'b11) ? ST_GOOD : ST_BAD;

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    field_count_next = field_count;
    digit_ok_next    = digit_ok;
    fidx             = field_count;
    st               = ST_NONE;
    result           = '0;

    case (phase)
      PH_START: begin
        running_xor_next = '0;
        field_count_next = '0;
        digit_ok_next    = '0;
        fidx             = '0;
        if (data_byte == CH_DOLLAR || data_byte == CH_BANG) begin
          phase_next       = PH_BODY;
          result.field_end = last_byte;
        end else begin
          phase_next = PH_BAD;
          st         = ST_BADSTART;
        end
      end
      PH_BODY: begin
        if (data_byte == CH_STAR) begin
          result.field_end = 1'b1;
          phase_next       = PH_DIG1;
        end else if (data_byte == CH_COMMA) begin
          running_xor_next = running_xor ^ data_byte;
          result.field_end = 1'b1;
          if (field_count < FIELD_MAX) begin
            field_count_next = field_count + 1'b1;
          end
        end else begin
          running_xor_next  = running_xor ^ data_byte;
          result.field_char = data_byte;
          result.char_valid = 1'b1;
          result.field_end  = last_byte;
        end
      end
      PH_DIG1: begin
        digit_ok_next = {1'b0, hex_v == {1'b0, running_xor[7:4]}};
        phase_next    = PH_DIG2;
        st            = ST_BAD;
      end
      PH_DIG2: begin
        if (hex_v == {1'b0, running_xor[3:0]}) begin
          digit_ok_next = digit_ok | 2'b10;
        end
        phase_next = PH_TRAIL;
        st         = ((digit_ok | {hex_v == {1'b0, running_xor[3:0]}, 1'b0}) == 2'b11)
                     ? ST_GOOD : ST_BAD;
      end
      PH_TRAIL: begin
        st = chk_status;
      end
      default: begin
        phase_next = PH_BAD;
        st         = ST_BADSTART;
      end
    endcase

    // the last byte closes the sentence and rearms for a start byte
    if (last_byte) begin
      phase_next = PH_START;
      result.sentence_end = 1'b1;
      result.status       = st;
    end

    result.field_index  = FIELD_IDX_W'(fidx);
    result.computed_sum = running_xor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      running_xor <= '0;
      field_count <= '0;
      digit_ok    <= '0;
    end else if (step) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      field_count <= field_count_next;
      digit_ok    <= digit_ok_next;
    end
  end

endmodule
